// ----- rtl/core/sfra_pkg.sv -----
// Package for the sequence-checked frame receiver with periodic acknowledge.
// Holds the item types, register reset values and content codes.
// No dependencies; every other file of the block uses it.
`timescale 1ns / 1ps

package sfra_pkg;

    // Width of the periodic acknowledge interval register.
    localparam int unsigned AckIntervalWidth = 8;
    // Interval register value after reset.
    localparam logic [AckIntervalWidth-1:0] AckIntervalReset = 8'd16;
    // Content kind code that marks a video frame.
    localparam logic [7:0] ContentVideo = 8'h01;

    // One parsed packet header.
    typedef struct packed {
        logic [31:0] packet_seq;
        logic [15:0] subframes_in_frame;
        logic [7:0]  content_kind;
        logic [7:0]  buffer_level;
    } t_pkt_item;

    // One result item.
    typedef struct packed {
        logic        accepted;
        logic        frame_start;
        logic        frame_done;
        logic        frame_queued;
        logic        ack_valid;
        logic [31:0] acked_seq;
        logic [31:0] ack_number;
        logic [7:0]  ack_level;
    } t_res_item;

    // One configuration write.
    typedef struct packed {
        logic [AckIntervalWidth-1:0] ack_interval;
    } t_cfg_item;

endpackage

// ----- rtl/core/sfra_pkt_if.sv -----
// Valid/ready channel that carries packet header items into the receiver.
// Depends on sfra_pkg for the item type.
`timescale 1ns / 1ps

interface sfra_pkt_if;
    logic                valid;
    logic                ready;
    sfra_pkg::t_pkt_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/sfra_res_if.sv -----
// Valid/ready channel that carries result items out of the receiver.
// Depends on sfra_pkg for the item type.
`timescale 1ns / 1ps

interface sfra_res_if;
    logic                valid;
    logic                ready;
    sfra_pkg::t_res_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/sfra_cfg_if.sv -----
// Valid/ready write channel for the acknowledge interval register.
// Depends on sfra_pkg for the item type.
`timescale 1ns / 1ps

interface sfra_cfg_if;
    logic                valid;
    logic                ready;
    sfra_pkg::t_cfg_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/seq_checked_frame_receiver_ack_top.sv -----
// Top level of the sequence-checked frame receiver with periodic acknowledge.
// Depends on sfra_pkg and the interfaces sfra_pkt_if, sfra_res_if, sfra_cfg_if.
`timescale 1ns / 1ps

// The receiver takes one parsed packet header per item and returns exactly one
// result item for it. Unless stalled, it accepts a new item in every cycle, so
// the sustained rate is one item per clock; a result appears in the output
// register in the cycle after its acceptance. The only hold on the input is the
// single result register: while it holds an item that the sink has not taken,
// the input is stalled, and it moves again in the same cycle that the sink
// takes the result. A packet whose sequence number differs from the expected
// one is dropped and answered with an acknowledge that names the expected
// number minus one; a matching packet advances the expected number, opens or
// continues a frame, and every ack_interval accepted packets causes an
// acknowledge that names the packet itself. An interval of zero behaves as 256
// because the interval counter is 8 bits wide and wraps. The interval register
// is written through its own channel, which is always ready; write it only
// while no item is in flight. There is no clearing pass after reset.
module seq_checked_frame_receiver_ack_top (
    input logic         i_clk,
    input logic         i_rst_n,
    sfra_pkt_if.sink    i_pkt,
    sfra_res_if.source  o_res,
    sfra_cfg_if.sink    i_cfg
);

    // Receiver state.
    logic [31:0]                           r_expected_seq;
    logic [31:0]                           r_acks_sent;
    logic [sfra_pkg::AckIntervalWidth-1:0] r_since_last_ack;
    logic [sfra_pkg::AckIntervalWidth-1:0] r_ack_interval;
    logic                                  r_in_frame_data;
    logic [15:0]                           r_frame_total;
    logic [15:0]                           r_subframes_seen;
    logic                                  r_frame_is_video;

    // Result register.
    logic                r_res_valid;
    sfra_pkg::t_res_item r_res;

    // Next values.
    logic [31:0]                           n_expected_seq;
    logic [31:0]                           n_acks_sent;
    logic [sfra_pkg::AckIntervalWidth-1:0] n_since_last_ack;
    logic                                  n_in_frame_data;
    logic [15:0]                           n_frame_total;
    logic [15:0]                           n_subframes_seen;
    logic                                  n_frame_is_video;
    sfra_pkg::t_res_item                   n_res;

    logic                                  pkt_fire;
    logic                                  seq_match;
    logic [sfra_pkg::AckIntervalWidth-1:0] since_inc;

    // The input moves whenever the result register is empty or is being
    // emptied in this cycle.
    assign i_pkt.ready = !r_res_valid || o_res.ready;
    assign pkt_fire    = i_pkt.valid && i_pkt.ready;

    assign o_res.valid = r_res_valid;
    assign o_res.data  = r_res;

    assign i_cfg.ready = 1'b1;

    assign seq_match = (i_pkt.data.packet_seq == r_expected_seq);
    assign since_inc = r_since_last_ack + 1'b1;

    // Per-item update. The state is only committed when the item is accepted.
    always_comb begin
        n_expected_seq   = r_expected_seq;
        n_acks_sent      = r_acks_sent;
        n_since_last_ack = r_since_last_ack;
        n_in_frame_data  = r_in_frame_data;
        n_frame_total    = r_frame_total;
        n_subframes_seen = r_subframes_seen;
        n_frame_is_video = r_frame_is_video;
        n_res            = '0;

        if (!seq_match) begin
            // Dropped packet: acknowledge the last in-order packet and restart
            // the interval count. The frame state stays as it is.
            n_res.ack_valid  = 1'b1;
            n_res.acked_seq  = r_expected_seq - 32'd1;
            n_res.ack_number = r_acks_sent;
            n_res.ack_level  = i_pkt.data.buffer_level;
            n_acks_sent      = r_acks_sent + 32'd1;
            n_since_last_ack = '0;
        end else begin
            n_res.accepted = 1'b1;
            n_expected_seq = r_expected_seq + 32'd1;

            if (!r_in_frame_data) begin
                // A start packet latches the frame's total and kind.
                n_frame_total     = i_pkt.data.subframes_in_frame;
                n_frame_is_video  = (i_pkt.data.content_kind == sfra_pkg::ContentVideo);
                n_in_frame_data   = 1'b1;
                n_res.frame_start = 1'b1;
            end else begin
                n_subframes_seen = r_subframes_seen + 16'd1;
            end

            // A zero total lets the start packet complete the frame at once.
            if (n_subframes_seen == n_frame_total) begin
                n_res.frame_done   = 1'b1;
                n_res.frame_queued = n_frame_is_video;
                n_subframes_seen   = '0;
                n_in_frame_data    = 1'b0;
            end

            n_since_last_ack = since_inc;
            if (since_inc == r_ack_interval) begin
                n_res.ack_valid  = 1'b1;
                n_res.acked_seq  = i_pkt.data.packet_seq;
                n_res.ack_number = r_acks_sent;
                n_res.ack_level  = i_pkt.data.buffer_level;
                n_acks_sent      = r_acks_sent + 32'd1;
                n_since_last_ack = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_seq   <= '0;
            r_acks_sent      <= '0;
            r_since_last_ack <= '0;
            r_ack_interval   <= sfra_pkg::AckIntervalReset;
            r_in_frame_data  <= 1'b0;
            r_frame_total    <= '0;
            r_subframes_seen <= '0;
            r_frame_is_video <= 1'b0;
            r_res_valid      <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_ack_interval <= i_cfg.data.ack_interval;
            end
            if (pkt_fire) begin
                r_expected_seq   <= n_expected_seq;
                r_acks_sent      <= n_acks_sent;
                r_since_last_ack <= n_since_last_ack;
                r_in_frame_data  <= n_in_frame_data;
                r_frame_total    <= n_frame_total;
                r_subframes_seen <= n_subframes_seen;
                r_frame_is_video <= n_frame_is_video;
                r_res_valid      <= 1'b1;
            end else if (o_res.ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    // The result payload needs no reset; it is only loaded with an item.
    always_ff @(posedge i_clk) begin
        if (pkt_fire) begin
            r_res <= n_res;
        end
    end

`ifndef SYNTHESIS
    // The input only stalls when a finished result is still waiting.
    a_stall_only_when_full: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !i_pkt.ready |-> (r_res_valid && !o_res.ready)
    ) else $error("input stalled with the result register free");

    // A queued frame is always a completed frame of an accepted packet.
    a_queued_implies_done: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid && r_res.frame_queued |-> r_res.frame_done && r_res.accepted
    ) else $error("frame queued without completion");

    // Every accepted packet advances the expected number by exactly one.
    a_seq_advances: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        pkt_fire && seq_match |=> r_expected_seq == $past(i_pkt.data.packet_seq) + 32'd1
    ) else $error("expected sequence number did not advance");

    // Every acknowledge that leaves bumps the acknowledge count.
    a_ack_counts: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        pkt_fire && n_res.ack_valid |=> r_acks_sent == $past(r_acks_sent) + 32'd1
    ) else $error("acknowledge count not incremented");

    // A dropped packet restarts the interval count.
    a_drop_clears_interval: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        pkt_fire && !seq_match |=> r_since_last_ack == '0
    ) else $error("interval count not cleared on drop");
`endif

endmodule

// ----- test/tb.sv -----
// Self-checking bench for seq_checked_frame_receiver_ack_top: header items in, result items out.
// Depends on sfra_pkg and the interfaces sfra_pkt_if, sfra_res_if and sfra_cfg_if.
`timescale 1ns / 1ps

module tb;

    // Tracks the receiver's sequence, frame and acknowledge state and owes
    // one result item for every header item that the block accepts.
    class seq_frame_tracker;
        logic [7:0]          interval;
        logic [31:0]         next_seq;
        logic [31:0]         acks_sent;
        logic [7:0]          since_ack;
        logic                in_frame;
        logic [15:0]         frame_total;
        logic [15:0]         seen;
        logic                frame_video;
        sfra_pkg::t_res_item owed_results[$];
        int                  errors;

        function new();
            interval    = sfra_pkg::AckIntervalReset;
            next_seq    = '0;
            acks_sent   = '0;
            since_ack   = '0;
            in_frame    = 1'b0;
            frame_total = '0;
            seen        = '0;
            frame_video = 1'b0;
            errors      = 0;
        endfunction

        function void load_interval(sfra_pkg::t_cfg_item c);
            interval = c.ack_interval;
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        // Fills in an acknowledge and bumps the running acknowledge count.
        function void fill_ack(inout sfra_pkg::t_res_item r, input logic [31:0] seq,
                               input logic [7:0] level);
            r.ack_valid  = 1'b1;
            r.acked_seq  = seq;
            r.ack_number = acks_sent;
            r.ack_level  = level;
            acks_sent    = acks_sent + 32'd1;
        endfunction

        function void take_header(sfra_pkg::t_pkt_item h);
            sfra_pkg::t_res_item r;
            r = '0;
            if (h.packet_seq != next_seq) begin
                // Out-of-order packet: dropped, acknowledge the last good one.
                fill_ack(r, next_seq - 32'd1, h.buffer_level);
                since_ack = '0;
            end else begin
                r.accepted = 1'b1;
                next_seq   = next_seq + 32'd1;
                if (!in_frame) begin
                    frame_total   = h.subframes_in_frame;
                    frame_video   = (h.content_kind == sfra_pkg::ContentVideo);
                    in_frame      = 1'b1;
                    r.frame_start = 1'b1;
                end else begin
                    seen = seen + 16'd1;
                end
                if (seen == frame_total) begin
                    r.frame_done   = 1'b1;
                    r.frame_queued = frame_video;
                    seen           = '0;
                    in_frame       = 1'b0;
                end
                since_ack = since_ack + 8'd1;
                if (since_ack == interval) begin
                    fill_ack(r, h.packet_seq, h.buffer_level);
                    since_ack = '0;
                end
            end
            owed_results.push_back(r);
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t ns: %s mismatch, expected %0h actual %0h",
                         $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_result(sfra_pkg::t_res_item got);
            sfra_pkg::t_res_item want;
            if (owed_results.size() == 0) begin
                $display("%0t ns: result item with nothing expected, actual %0h",
                         $time, got);
                errors++;
                return;
            end
            want = owed_results.pop_front();
            compare("accepted", 32'(want.accepted), 32'(got.accepted));
            compare("frame_start", 32'(want.frame_start), 32'(got.frame_start));
            compare("frame_done", 32'(want.frame_done), 32'(got.frame_done));
            compare("frame_queued", 32'(want.frame_queued), 32'(got.frame_queued));
            compare("ack_valid", 32'(want.ack_valid), 32'(got.ack_valid));
            compare("acked_seq", want.acked_seq, got.acked_seq);
            compare("ack_number", want.ack_number, got.ack_number);
            compare("ack_level", 32'(want.ack_level), 32'(got.ack_level));
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    sfra_pkt_if pkt_ch ();
    sfra_res_if res_ch ();
    sfra_cfg_if cfg_ch ();

    seq_checked_frame_receiver_ack_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pkt   (pkt_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    seq_frame_tracker tracker = new();

    // Idling knobs, in percent of cycles, set by the main sequence per phase.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // Long receiver hold-off: the main sequence bumps hold_asked, the receiver
    // process owns the countdown so that only one process writes each variable.
    int hold_asked  = 0;
    int hold_served = 0;
    int hold_left   = 0;

    always #5 i_clk = ~i_clk;

    // The receiver side drives ready at the falling edge.
    always @(negedge i_clk) begin
        if (hold_asked != hold_served) begin
            hold_served = hold_asked;
            hold_left   = 160;
        end
        if (hold_left > 0) begin
            hold_left    = hold_left - 1;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // All handshakes are observed at the rising edge, where the driven
    // inputs and the block's registered outputs are both settled.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                tracker.load_interval(cfg_ch.data);
            end
            if (pkt_ch.valid && pkt_ch.ready) begin
                tracker.take_header(pkt_ch.data);
            end
            if (res_ch.valid && res_ch.ready) begin
                tracker.check_result(res_ch.data);
            end
        end
    end

    function automatic sfra_pkg::t_pkt_item make_hdr(logic [31:0] seq, logic [15:0] total,
                                                     logic [7:0] kind, logic [7:0] level);
        sfra_pkg::t_pkt_item h;
        h.packet_seq         = seq;
        h.subframes_in_frame = total;
        h.content_kind       = kind;
        h.buffer_level       = level;
        return h;
    endfunction

    // Entered and left at a falling edge. Valid is not lowered after the
    // accepting edge, so back-to-back items keep it high without a glitch.
    task automatic push_header(sfra_pkg::t_pkt_item h);
        while ($urandom_range(99) < send_idle_pct) begin
            pkt_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        pkt_ch.valid <= 1'b1;
        pkt_ch.data  <= h;
        do @(posedge i_clk); while (!pkt_ch.ready);
        @(negedge i_clk);
    endtask

    // Waits until every owed result has come back, then lets the pipeline
    // drain before the interval register is written.
    task automatic drain();
        pkt_ch.valid <= 1'b0;
        while (tracker.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_interval(logic [7:0] value);
        drain();
        cfg_ch.valid             <= 1'b1;
        cfg_ch.data.ack_interval <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Random headers. Most follow the expected sequence with random content;
    // noise_pct of them are broken: repeats, skips, or arbitrary numbers.
    task automatic run_headers(int count, int noise_pct, int hold_at);
        logic [31:0] seq;
        logic [15:0] total;
        logic [7:0]  kind;
        for (int i = 0; i < count; i++) begin
            if (i == hold_at) begin
                hold_asked++;
            end
            seq = tracker.next_seq;
            if ($urandom_range(99) < noise_pct) begin
                case ($urandom_range(2))
                    0: seq = seq + 32'd1;
                    1: seq = seq - 32'd1;
                    default: seq = $urandom;
                endcase
            end
            if (tracker.in_frame) begin
                // The total is ignored inside a frame, so any value will do.
                total = 16'($urandom);
            end else if ($urandom_range(99) < 5) begin
                total = 16'($urandom_range(40, 9));
            end else begin
                total = 16'($urandom_range(6));
            end
            kind = ($urandom_range(1) == 0) ? sfra_pkg::ContentVideo : 8'($urandom);
            push_header(make_hdr(seq, total, kind, 8'($urandom)));
        end
    endtask

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        pkt_ch.valid = 1'b0;
        pkt_ch.data  = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        res_ch.ready = 1'b0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part at the reset interval of 16.
        // A mismatch while zero is expected acknowledges the wrapped value.
        push_header(make_hdr(32'hFFFF_FFFF, 16'h0000, 8'h00, 8'hAA));
        // A zero total opens and completes a video frame in one packet.
        push_header(make_hdr(32'd0, 16'h0000, sfra_pkg::ContentVideo, 8'h00));
        push_header(make_hdr(32'd1, 16'd2, 8'h00, 8'h11));
        // A drop inside an open frame keeps the frame and clears the interval count.
        push_header(make_hdr(32'd5, 16'hFFFF, 8'hFF, 8'hFF));
        push_header(make_hdr(32'd2, 16'hFFFF, 8'hFF, 8'h22));
        // Completion of a non-video frame releases it.
        push_header(make_hdr(32'd3, 16'h0000, 8'h00, 8'h33));
        push_header(make_hdr(32'd4, 16'd1, sfra_pkg::ContentVideo, 8'h44));
        push_header(make_hdr(32'd5, 16'd0, 8'h00, 8'h55));
        push_header(make_hdr(32'd6, 16'd0, 8'hFF, 8'h66));
        // A clean run long enough to reach the periodic acknowledge.
        for (int k = 0; k < 14; k++) begin
            push_header(make_hdr(32'd7 + 32'(k), 16'(k % 3), 8'(k & 1), 8'(k * 37)));
        end

        // Interval 1: every accepted packet acknowledged; no idling, with one
        // long receiver hold-off while items keep being offered.
        write_interval(8'd1);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_headers(150, 10, 40);

        // Largest nonzero interval with a mostly idle sender.
        write_interval(8'd255);
        send_idle_pct  = 87;
        recv_stall_pct = 0;
        run_headers(150, 8, -1);

        // Interval zero behaves as 256: a clean run of 300 reaches the wrap.
        write_interval(8'd0);
        send_idle_pct  = 0;
        recv_stall_pct = 87;
        run_headers(300, 0, -1);

        // If the count sits above 3, it must wrap through 255 first.
        write_interval(8'd3);
        send_idle_pct  = 32;
        recv_stall_pct = 32;
        run_headers(200, 15, -1);

        write_interval(sfra_pkg::AckIntervalReset);
        send_idle_pct  = 32;
        recv_stall_pct = 0;
        run_headers(150, 10, -1);

        // Largest total, which on a frame start stays open to the end of the run.
        push_header(make_hdr(tracker.next_seq, 16'hFFFF, 8'hFF, 8'hFF));

        recv_stall_pct = 0;
        drain();
        if (tracker.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/sfra_pkg.sv
rtl/core/sfra_pkt_if.sv
rtl/core/sfra_res_if.sv
rtl/core/sfra_cfg_if.sv
rtl/core/seq_checked_frame_receiver_ack_top.sv
test/tb.sv
